@@ design/assert_macros.svh @@
// Assertion macros shared by the recording interval index RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// implication checked at every clock edge out of reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/rii_pkg.sv @@
// Package for the recording interval index: widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package rii_pkg;

  localparam int MAX_SEGMENTS_DEF = 32;
  localparam int TW    = 63;
  localparam int TAGW  = 16;
  localparam int IDXOW = 5;
  localparam int CNTOW = 6;
  localparam int KINDW = 3;
  localparam int CFGIW = 2;

  typedef enum logic [1:0] {
    ACT_LOAD, ACT_MAP, ACT_NEXT, ACT_EXPORT
  } action_t;

  typedef enum logic [KINDW-1:0] {
    KIND_GAP, KIND_SUMMARY, KIND_MAP, KIND_NEXT, KIND_EXPORT
  } kind_t;

  typedef enum logic [CFGIW-1:0] {
    CFG_DAY_START, CFG_DAY_END, CFG_GAP_THRESHOLD
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EM_GAP, EM_SUM, EM_MAP, EM_NEXT, EM_EXP, EM_EXP_EMPTY
  } emit_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_B_INIT, S_B_SCAN, S_B_DIFF, S_B_GAP, S_B_WRITE, S_B_ACC,
    S_B_TDIFF, S_B_TGAP, S_B_SUM, S_Q_MID, S_Q_CMP, S_Q_FETCH, S_Q_EVAL,
    S_Q_EMIT, S_X_RD, S_X_CALC, S_X_EMIT, S_X_EMPTY
  } ctl_state_t;

  typedef struct packed {
    logic      accept;
    logic      load;
    logic      q_init;
    logic      x_init;
    logic      build_init;
    logic      scan_start;
    logic      scan_run;
    logic      diff_seg;
    logic      diff_tail;
    logic      write_tbl;
    logic      acc_cov;
    logic      build_done;
    logic      q_read_mid;
    logic      q_cmp;
    logic      q_fetch;
    logic      q_eval;
    logic      q_prev;
    logic      x_read;
    logic      x_calc;
    logic      x_step;
    logic      emit;
    logic      emit_last;
    emit_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic win_ok;
    logic scan_done;
    logic have_best;
    logic gap_big;
    logic tbl_nonempty;
    logic q_more;
    logic x_last;
    logic out_free;
  } dp_stat_t;

endpackage

@@ design/rii_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rii_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

endmodule

@@ design/rii_ctrl.sv @@
// Controller FSM for the recording interval index: sequences load, build,
// query and export. Depends on rii_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rii_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  input  logic              in_last_seg,
  output logic              in_stall,
  input  rii_pkg::dp_stat_t stat,
  output rii_pkg::dp_cmd_t  cmd
);
  import rii_pkg::*;

  ctl_state_t state_r, state_nxt;
  action_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= ACT_LOAD;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          op_nxt     = action_t'(in_action);
          case (action_t'(in_action))
            ACT_LOAD: begin
              cmd.load = 1'b1;
              if (in_last_seg) state_nxt = S_B_INIT;
            end
            ACT_MAP, ACT_NEXT: begin
              cmd.q_init = 1'b1;
              state_nxt  = S_Q_MID;
            end
            default: begin
              cmd.x_init = 1'b1;
              state_nxt  = stat.tbl_nonempty ? S_X_RD : S_X_EMPTY;
            end
          endcase
        end
      end
      S_B_INIT: begin
        cmd.build_init = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = stat.win_ok ? S_B_SCAN : S_B_SUM;
      end
      S_B_SCAN: begin
        cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          if (stat.have_best)         state_nxt = S_B_DIFF;
          else if (stat.tbl_nonempty) state_nxt = S_B_TDIFF;
          else                        state_nxt = S_B_SUM;
        end
      end
      S_B_DIFF: begin
        cmd.diff_seg = 1'b1;
        state_nxt = S_B_GAP;
      end
      S_B_GAP: begin
        if (!stat.gap_big) begin
          state_nxt = S_B_WRITE;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_GAP;
          state_nxt = S_B_WRITE;
        end
      end
      S_B_WRITE: begin
        cmd.write_tbl = 1'b1;
        state_nxt = S_B_ACC;
      end
      S_B_ACC: begin
        cmd.acc_cov    = 1'b1;
        cmd.scan_start = 1'b1;
        state_nxt = S_B_SCAN;
      end
      S_B_TDIFF: begin
        cmd.diff_tail = 1'b1;
        state_nxt = S_B_TGAP;
      end
      S_B_TGAP: begin
        if (!stat.gap_big) begin
          state_nxt = S_B_SUM;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = EM_GAP;
          state_nxt = S_B_SUM;
        end
      end
      S_B_SUM: begin
        if (stat.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_last  = 1'b1;
          cmd.sel        = EM_SUM;
          cmd.build_done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_Q_MID: begin
        if (stat.q_more) begin
          cmd.q_read_mid = 1'b1;
          state_nxt = S_Q_CMP;
        end else begin
          state_nxt = S_Q_FETCH;
        end
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_Q_MID;
      end
      S_Q_FETCH: begin
        cmd.q_fetch = 1'b1;
        cmd.q_prev  = (op_r == ACT_MAP);
        state_nxt = S_Q_EVAL;
      end
      S_Q_EVAL: begin
        cmd.q_eval = 1'b1;
        cmd.q_prev = (op_r == ACT_MAP);
        state_nxt = S_Q_EMIT;
      end
      S_Q_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.sel       = (op_r == ACT_MAP) ? EM_MAP : EM_NEXT;
          state_nxt = S_IDLE;
        end
      end
      S_X_RD: begin
        cmd.x_read = 1'b1;
        state_nxt = S_X_CALC;
      end
      S_X_CALC: begin
        cmd.x_calc = 1'b1;
        state_nxt = S_X_EMIT;
      end
      S_X_EMIT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = stat.x_last;
          cmd.sel       = EM_EXP;
          cmd.x_step    = 1'b1;
          state_nxt = stat.x_last ? S_IDLE : S_X_RD;
        end
      end
      S_X_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          cmd.sel       = EM_EXP_EMPTY;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `ASSERT_IMPL(a_emit_needs_room, cmd.emit, stat.out_free, "result pushed into a full output register")
  `ASSERT_IMPL(a_accept_only_idle, cmd.accept, state_r == S_IDLE && in_valid, "transaction taken while busy")

endmodule

@@ design/rii_dp.sv @@
// Datapath for the recording interval index: config registers, pending and
// table RAMs, build scan pipeline, query search, export walk, output register.
// Depends on rii_pkg, rii_ram and assert_macros.svh.
`include "assert_macros.svh"
module rii_dp #(
  parameter int MAX_SEGMENTS = rii_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rii_pkg::CFGIW-1:0]   cfg_index,
  input  logic [rii_pkg::TW-1:0]      cfg_wdata,
  input  logic [rii_pkg::TW-1:0]      in_seg_start,
  input  logic [rii_pkg::TW-1:0]      in_seg_end,
  input  logic [rii_pkg::TAGW-1:0]    in_seg_tag,
  input  logic [rii_pkg::TW-1:0]      in_query_time,
  input  rii_pkg::dp_cmd_t            cmd,
  output rii_pkg::dp_stat_t           stat,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [rii_pkg::KINDW-1:0]   out_result_kind,
  output logic                        out_hit,
  output logic [rii_pkg::IDXOW-1:0]   out_entry_index,
  output logic [rii_pkg::TAGW-1:0]    out_entry_tag,
  output logic [rii_pkg::TW-1:0]      out_span_start,
  output logic [rii_pkg::TW-1:0]      out_span_end,
  output logic [rii_pkg::TW-1:0]      out_offset_time,
  output logic [rii_pkg::TW-1:0]      out_length_time,
  output logic [rii_pkg::CNTOW-1:0]   out_segment_count,
  output logic [rii_pkg::CNTOW-1:0]   out_gap_count,
  output logic                        out_overflow,
  output logic                        out_last_of_run
);
  import rii_pkg::*;

  localparam int IW   = $clog2(MAX_SEGMENTS);
  localparam int CW   = $clog2(MAX_SEGMENTS + 1);
  localparam int GW   = $clog2(MAX_SEGMENTS + 2);
  localparam int ENTW = 2 * TW + TAGW;

  function automatic logic [TW-1:0] clip(input logic [TW-1:0] v, input logic [TW-1:0] lo,
                                         input logic [TW-1:0] hi);
    logic [TW-1:0] r;
    r = v;
    if (v < lo)      r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // config and build state
  logic [TW-1:0]   day_start_r, day_end_r, gap_thr_r, bds_r;
  logic [CW-1:0]   pcnt_r, tcnt_r;
  logic            povf_r;
  logic [GW-1:0]   gaps_r;
  logic [TW-1:0]   cov_r, last_r, diff_r, gap_hi_r, dur_r;
  logic            gt_r, wr_ok_r;

  // scan pipeline
  logic [CW-1:0]   sc_i_r;
  logic            v1_r, v2_r;
  logic [IW-1:0]   idx1_r, idx2_r;
  logic [TW-1:0]   a2_r, b2_r;
  logic [TAGW-1:0] t2_r;
  logic            have_best_r, have_prev_r;
  logic [TW-1:0]   ba_r, bb_r, pa_r;
  logic [TAGW-1:0] bt_r;
  logic [IW-1:0]   bidx_r, pidx_r;
  logic            issue, cand;

  // query and export
  logic [TW-1:0]   qt_r;
  logic [CW-1:0]   lo_r, hi_r, mid_r, mid_c;
  logic            q_hit_r;
  logic [IW-1:0]   q_idx_r;
  logic [TAGW-1:0] q_tag_r;
  logic [TW-1:0]   q_off_r;
  logic [CW-1:0]   xi_r;
  logic [TW-1:0]   acc_r, xd_r, xrel_r;
  logic [TAGW-1:0] xt_r;

  // memories
  logic            p_we, t_we;
  logic [ENTW-1:0] p_rd, t_rd;
  logic [IW-1:0]   t_raddr;
  logic [TW-1:0]   seg_s, p_s, p_e, t_s, t_e;
  logic [TAGW-1:0] p_t, t_t;
  logic            out_valid_r;

  assign {p_s, p_e, p_t} = p_rd;
  assign {t_s, t_e, t_t} = t_rd;

  assign p_we  = cmd.load && (pcnt_r < CW'(MAX_SEGMENTS));
  assign issue = cmd.scan_run && (sc_i_r < pcnt_r);
  assign seg_s = gt_r ? ba_r : last_r;
  assign t_we  = cmd.write_tbl && (bb_r > seg_s);
  assign mid_c = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  always_comb begin
    t_raddr = mid_c[IW-1:0];
    if (cmd.q_fetch) t_raddr = cmd.q_prev ? IW'(lo_r - 1'b1) : lo_r[IW-1:0];
    if (cmd.x_read)  t_raddr = xi_r[IW-1:0];
  end

  assign cand = v2_r && (b2_r > a2_r)
             && (!have_prev_r || (a2_r > pa_r) || ((a2_r == pa_r) && (idx2_r > pidx_r)))
             && (!have_best_r || (a2_r < ba_r));

  rii_ram #(.WIDTH(ENTW), .DEPTH(MAX_SEGMENTS), .AW(IW)) u_pend (
    .clk     (clk),
    .we      (p_we),
    .waddr   (pcnt_r[IW-1:0]),
    .wdata   ({in_seg_start, in_seg_end, in_seg_tag}),
    .raddr   (sc_i_r[IW-1:0]),
    .rd_data (p_rd)
  );

  rii_ram #(.WIDTH(ENTW), .DEPTH(MAX_SEGMENTS), .AW(IW)) u_tbl (
    .clk     (clk),
    .we      (t_we),
    .waddr   (tcnt_r[IW-1:0]),
    .wdata   ({seg_s, bb_r, bt_r}),
    .raddr   (t_raddr),
    .rd_data (t_rd)
  );

  assign out_valid       = out_valid_r;
  assign stat.win_ok       = day_end_r > day_start_r;
  assign stat.scan_done    = (sc_i_r == pcnt_r) && !v1_r && !v2_r;
  assign stat.have_best    = have_best_r;
  assign stat.gap_big      = gt_r && (diff_r > gap_thr_r);
  assign stat.tbl_nonempty = tcnt_r != '0;
  assign stat.q_more       = lo_r < hi_r;
  assign stat.x_last       = xi_r == CW'(tcnt_r - 1'b1);
  assign stat.out_free     = !out_valid_r || !out_stall;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_start_r <= '0;
      day_end_r   <= '0;
      gap_thr_r   <= '0;
      bds_r       <= '0;
      pcnt_r      <= '0;
      povf_r      <= 1'b0;
      tcnt_r      <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      have_best_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DAY_START:     day_start_r <= cfg_wdata;
          CFG_DAY_END:       day_end_r   <= cfg_wdata;
          CFG_GAP_THRESHOLD: gap_thr_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        if (p_we) pcnt_r <= pcnt_r + 1'b1;
        else      povf_r <= 1'b1;
      end
      if (cmd.build_init) begin
        tcnt_r <= '0;
        bds_r  <= day_start_r;
      end
      if (cmd.acc_cov && wr_ok_r) tcnt_r <= tcnt_r + 1'b1;
      if (cmd.build_done) begin
        pcnt_r <= '0;
        povf_r <= 1'b0;
      end
      v1_r <= issue;
      v2_r <= v1_r;
      if (cand) have_best_r <= 1'b1;
      if (cmd.scan_start) begin
        v1_r        <= 1'b0;
        v2_r        <= 1'b0;
        have_best_r <= 1'b0;
      end
      if (cmd.emit)        out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) qt_r <= in_query_time;
    if (cmd.build_init) begin
      cov_r       <= '0;
      gaps_r      <= '0;
      last_r      <= day_start_r;
      have_prev_r <= 1'b0;
    end
    if (cmd.scan_start) sc_i_r <= '0;
    else if (issue)     sc_i_r <= sc_i_r + 1'b1;
    idx1_r <= sc_i_r[IW-1:0];
    idx2_r <= idx1_r;
    a2_r   <= clip(p_s, day_start_r, day_end_r);
    b2_r   <= clip(p_e, day_start_r, day_end_r);
    t2_r   <= p_t;
    if (cand) begin
      ba_r   <= a2_r;
      bb_r   <= b2_r;
      bt_r   <= t2_r;
      bidx_r <= idx2_r;
    end
    if (cmd.diff_seg) begin
      gt_r        <= ba_r > last_r;
      diff_r      <= ba_r - last_r;
      gap_hi_r    <= ba_r;
      pa_r        <= ba_r;
      pidx_r      <= bidx_r;
      have_prev_r <= 1'b1;
    end
    if (cmd.diff_tail) begin
      gt_r     <= day_end_r > last_r;
      diff_r   <= day_end_r - last_r;
      gap_hi_r <= day_end_r;
    end
    if (cmd.write_tbl) begin
      wr_ok_r <= bb_r > seg_s;
      dur_r   <= bb_r - seg_s;
    end
    if (cmd.acc_cov && wr_ok_r) begin
      cov_r  <= cov_r + dur_r;
      last_r <= bb_r;
    end
    if (cmd.emit && cmd.sel == EM_GAP) gaps_r <= gaps_r + 1'b1;

    if (cmd.q_init) begin
      lo_r <= '0;
      hi_r <= tcnt_r;
    end
    if (cmd.q_read_mid) mid_r <= mid_c;
    if (cmd.q_cmp) begin
      if (t_s <= qt_r) lo_r <= mid_r + 1'b1;
      else             hi_r <= mid_r;
    end
    if (cmd.q_eval) begin
      q_hit_r <= 1'b0;
      q_idx_r <= '0;
      q_tag_r <= '0;
      q_off_r <= '0;
      if (cmd.q_prev) begin
        if (lo_r != '0 && qt_r < t_e) begin
          q_hit_r <= 1'b1;
          q_idx_r <= IW'(lo_r - 1'b1);
          q_tag_r <= t_t;
          q_off_r <= qt_r - t_s;
        end
      end else if (lo_r < tcnt_r) begin
        q_hit_r <= 1'b1;
        q_idx_r <= lo_r[IW-1:0];
        q_tag_r <= t_t;
      end
    end

    if (cmd.x_init) begin
      xi_r  <= '0;
      acc_r <= '0;
    end
    if (cmd.x_calc) begin
      xd_r   <= t_e - t_s;
      xrel_r <= t_s - bds_r;
      xt_r   <= t_t;
    end
    if (cmd.x_step) begin
      xi_r  <= xi_r + 1'b1;
      acc_r <= acc_r + xd_r;
    end

    if (cmd.emit) begin
      out_result_kind   <= KIND_GAP;
      out_hit           <= 1'b0;
      out_entry_index   <= '0;
      out_entry_tag     <= '0;
      out_span_start    <= '0;
      out_span_end      <= '0;
      out_offset_time   <= '0;
      out_length_time   <= '0;
      out_segment_count <= '0;
      out_gap_count     <= '0;
      out_overflow      <= 1'b0;
      out_last_of_run   <= cmd.emit_last;
      case (cmd.sel)
        EM_GAP: begin
          out_span_start <= last_r;
          out_span_end   <= gap_hi_r;
        end
        EM_SUM: begin
          out_result_kind   <= KIND_SUMMARY;
          out_length_time   <= cov_r;
          out_segment_count <= CNTOW'(tcnt_r);
          out_gap_count     <= CNTOW'(gaps_r);
          out_overflow      <= povf_r;
        end
        EM_MAP: begin
          out_result_kind <= KIND_MAP;
          out_hit         <= q_hit_r;
          out_entry_index <= IDXOW'(q_idx_r);
          out_entry_tag   <= q_tag_r;
          out_offset_time <= q_off_r;
        end
        EM_NEXT: begin
          out_result_kind <= KIND_NEXT;
          out_hit         <= q_hit_r;
          out_entry_index <= IDXOW'(q_idx_r);
          out_entry_tag   <= q_tag_r;
        end
        EM_EXP: begin
          out_result_kind <= KIND_EXPORT;
          out_hit         <= 1'b1;
          out_entry_index <= IDXOW'(xi_r);
          out_entry_tag   <= xt_r;
          out_span_start  <= xrel_r;
          out_offset_time <= acc_r;
          out_length_time <= xd_r;
        end
        EM_EXP_EMPTY: out_result_kind <= KIND_EXPORT;
        default: ;
      endcase
    end
  end

  `ASSERT_NEVER(a_pcnt_range, pcnt_r > CW'(MAX_SEGMENTS), "pending count beyond capacity")
  `ASSERT_NEVER(a_tbl_write_full, t_we && tcnt_r >= CW'(MAX_SEGMENTS), "table write past capacity")

endmodule

@@ design/recording_interval_index.sv @@
// Top level of the recording interval index: controller plus datapath.
// Depends on rii_pkg, rii_ctrl, rii_dp (and rii_ram below it).
//
// Input channel (in_valid/in_stall) carries one transaction per action:
// load a segment, map a time, find the next segment, or export the table.
// Result channel (out_valid/out_stall) returns the results of a transaction,
// the final one flagged by out_last_of_run. cfg_we writes day_start,
// day_end and gap_threshold by index; the user must do so only while the
// block is idle, which the block does not enforce. Loads without the last
// flag leave the block idle, ready for the next transaction. Map and next
// run a binary search over the table RAM port. Export emits one result per
// table entry (a single empty one if the table is empty). A build scans
// the pending RAM once per selected segment and once more, via its one read port.
// Reset clears counts, config registers and the output valid; stores need no clear.
// One output register sits between the sides: in_stall drops as soon as
// the last result is loaded there, and while out_stall is high the held
// result stays put and further results wait inside the block.
module recording_interval_index #(
  parameter int MAX_SEGMENTS = rii_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rii_pkg::CFGIW-1:0]   cfg_index,
  input  logic [rii_pkg::TW-1:0]      cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_action,
  input  logic [rii_pkg::TW-1:0]      in_seg_start,
  input  logic [rii_pkg::TW-1:0]      in_seg_end,
  input  logic [rii_pkg::TAGW-1:0]    in_seg_tag,
  input  logic                        in_last_seg,
  input  logic [rii_pkg::TW-1:0]      in_query_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rii_pkg::KINDW-1:0]   out_result_kind,
  output logic                        out_hit,
  output logic [rii_pkg::IDXOW-1:0]   out_entry_index,
  output logic [rii_pkg::TAGW-1:0]    out_entry_tag,
  output logic [rii_pkg::TW-1:0]      out_span_start,
  output logic [rii_pkg::TW-1:0]      out_span_end,
  output logic [rii_pkg::TW-1:0]      out_offset_time,
  output logic [rii_pkg::TW-1:0]      out_length_time,
  output logic [rii_pkg::CNTOW-1:0]   out_segment_count,
  output logic [rii_pkg::CNTOW-1:0]   out_gap_count,
  output logic                        out_overflow,
  output logic                        out_last_of_run
);
  import rii_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rii_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_action   (in_action),
    .in_last_seg (in_last_seg),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  rii_dp #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_seg_start      (in_seg_start),
    .in_seg_end        (in_seg_end),
    .in_seg_tag        (in_seg_tag),
    .in_query_time     (in_query_time),
    .cmd               (cmd),
    .stat              (stat),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_hit           (out_hit),
    .out_entry_index   (out_entry_index),
    .out_entry_tag     (out_entry_tag),
    .out_span_start    (out_span_start),
    .out_span_end      (out_span_end),
    .out_offset_time   (out_offset_time),
    .out_length_time   (out_length_time),
    .out_segment_count (out_segment_count),
    .out_gap_count     (out_gap_count),
    .out_overflow      (out_overflow),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

@@ dv/tb_top.sv @@
// Testbench for recording_interval_index: drives load, map, next and export
// transactions, predicts every result in a scoreboard class and checks them.
// Depends on rii_pkg and the recording_interval_index RTL.
module tb_top;
  import rii_pkg::*;

  localparam logic [TW-1:0] TMAX = {TW{1'b1}};
  localparam int WD_LIMIT = 40000;

  typedef struct {
    action_t         action;
    logic [TW-1:0]   seg_start;
    logic [TW-1:0]   seg_end;
    logic [TAGW-1:0] seg_tag;
    logic            last_seg;
    logic [TW-1:0]   query_time;
  } txn_t;

  typedef struct {
    kind_t            kind;
    logic             hit;
    logic [IDXOW-1:0] entry_index;
    logic [TAGW-1:0]  entry_tag;
    logic [TW-1:0]    span_start;
    logic [TW-1:0]    span_end;
    logic [TW-1:0]    offset_time;
    logic [TW-1:0]    length_time;
    logic [CNTOW-1:0] segment_count;
    logic [CNTOW-1:0] gap_count;
    logic             overflow;
    logic             last_of_run;
  } result_t;

  class index_scoreboard;
    localparam int NSEG = MAX_SEGMENTS_DEF;
    logic [TW-1:0]   day_start, day_end, gap_threshold, built_day_start;
    logic [TW-1:0]   pend_start[NSEG], pend_end[NSEG];
    logic [TAGW-1:0] pend_tag[NSEG];
    int              pend_count;
    logic            pend_overflow;
    logic [TW-1:0]   tbl_start[NSEG], tbl_end[NSEG];
    logic [TAGW-1:0] tbl_tag[NSEG];
    int              tbl_count;
    result_t         expected_results[$];
    int              errors;

    function new();
      day_start = '0; day_end = '0; gap_threshold = '0; built_day_start = '0;
      pend_count = 0; pend_overflow = 1'b0; tbl_count = 0; errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    function void add_expected(result_t r);
      expected_results = {expected_results, r};
    endfunction

    function void set_reg(cfg_idx_t idx, logic [TW-1:0] v);
      case (idx)
        CFG_DAY_START: day_start = v;
        CFG_DAY_END: day_end = v;
        default: gap_threshold = v;
      endcase
    endfunction

    function result_t blank(kind_t k);
      result_t r;
      r = '{kind: k, default: '0};
      return r;
    endfunction

    function logic [TW-1:0] clip(logic [TW-1:0] v, logic [TW-1:0] lo, logic [TW-1:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void build_table();
      logic [TW-1:0]   rs[NSEG], re[NSEG];
      logic [TAGW-1:0] rt[NSEG];
      logic [TW-1:0]   a, b, s, last, covered, te;
      int              nraw, p, gaps;
      result_t         r;
      nraw = 0; gaps = 0; covered = '0;
      tbl_count = 0;
      built_day_start = day_start;
      if (day_end > day_start) begin
        for (int i = 0; i < pend_count; i++) begin
          a = clip(pend_start[i], day_start, day_end);
          b = clip(pend_end[i], day_start, day_end);
          if (b > a) begin
            p = nraw;
            while (p > 0 && rs[p-1] > a) begin
              rs[p] = rs[p-1]; re[p] = re[p-1]; rt[p] = rt[p-1];
              p--;
            end
            rs[p] = a; re[p] = b; rt[p] = pend_tag[i];
            nraw++;
          end
        end
        if (nraw > 0) begin
          last = day_start;
          for (int i = 0; i < nraw; i++) begin
            s = rs[i] > last ? rs[i] : last;
            if (rs[i] > last && rs[i] - last > gap_threshold) begin
              r = blank(KIND_GAP); r.span_start = last; r.span_end = rs[i];
              add_expected(r);
              gaps++;
            end
            if (re[i] > s) begin
              tbl_start[tbl_count] = s; tbl_end[tbl_count] = re[i];
              tbl_tag[tbl_count] = rt[i];
              tbl_count++;
              covered += re[i] - s;
              last = re[i];
            end
          end
          if (tbl_count > 0) begin
            te = tbl_end[tbl_count-1];
            if (day_end > te && day_end - te > gap_threshold) begin
              r = blank(KIND_GAP); r.span_start = te; r.span_end = day_end;
              add_expected(r);
              gaps++;
            end
          end else begin
            r = blank(KIND_GAP); r.span_start = day_start; r.span_end = day_end;
            add_expected(r);
            gaps++;
          end
        end
      end
      r = blank(KIND_SUMMARY);
      r.length_time = covered; r.segment_count = CNTOW'(tbl_count);
      r.gap_count = CNTOW'(gaps);
      r.overflow = pend_overflow;
      add_expected(r);
      pend_count = 0;
      pend_overflow = 1'b0;
    endfunction

    function void note_transaction(txn_t t);
      int      before_n, i;
      result_t r;
      logic [TW-1:0] acc;
      before_n = expected_results.size();
      case (t.action)
        ACT_LOAD: begin
          if (pend_count < NSEG) begin
            pend_start[pend_count] = t.seg_start;
            pend_end[pend_count] = t.seg_end;
            pend_tag[pend_count] = t.seg_tag;
            pend_count++;
          end else pend_overflow = 1'b1;
          if (t.last_seg) build_table();
        end
        ACT_MAP: begin
          r = blank(KIND_MAP);
          if (tbl_count > 0 && t.query_time >= tbl_start[0]) begin
            i = 0;
            while (i < tbl_count && tbl_start[i] <= t.query_time) i++;
            i--;
            if (t.query_time < tbl_end[i]) begin
              r.hit = 1'b1; r.entry_index = IDXOW'(i); r.entry_tag = tbl_tag[i];
              r.offset_time = t.query_time - tbl_start[i];
            end
          end
          add_expected(r);
        end
        ACT_NEXT: begin
          r = blank(KIND_NEXT);
          i = 0;
          while (i < tbl_count && tbl_start[i] <= t.query_time) i++;
          if (i < tbl_count) begin
            r.hit = 1'b1; r.entry_index = IDXOW'(i); r.entry_tag = tbl_tag[i];
          end
          add_expected(r);
        end
        default: begin
          acc = '0;
          if (tbl_count == 0) add_expected(blank(KIND_EXPORT));
          for (int k = 0; k < tbl_count; k++) begin
            r = blank(KIND_EXPORT);
            r.hit = 1'b1; r.entry_index = IDXOW'(k); r.entry_tag = tbl_tag[k];
            r.span_start = tbl_start[k] - built_day_start;
            r.offset_time = acc;
            r.length_time = tbl_end[k] - tbl_start[k];
            add_expected(r);
            acc += r.length_time;
          end
        end
      endcase
      if (expected_results.size() > before_n)
        expected_results[expected_results.size()-1].last_of_run = 1'b1;
    endfunction

    task cmp(string nm, logic [TW-1:0] got, logic [TW-1:0] exp);
      if (got !== exp) report($sformatf("%s got %0h expected %0h", nm, got, exp));
    endtask

    task check_result(result_t g);
      result_t e;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result of kind %0d", g.kind));
        return;
      end
      e = expected_results.pop_front();
      cmp("result_kind", g.kind, e.kind);
      cmp("hit", g.hit, e.hit);
      cmp("entry_index", g.entry_index, e.entry_index);
      cmp("entry_tag", g.entry_tag, e.entry_tag);
      cmp("span_start", g.span_start, e.span_start);
      cmp("span_end", g.span_end, e.span_end);
      cmp("offset_time", g.offset_time, e.offset_time);
      cmp("length_time", g.length_time, e.length_time);
      cmp("segment_count", g.segment_count, e.segment_count);
      cmp("gap_count", g.gap_count, e.gap_count);
      cmp("overflow", g.overflow, e.overflow);
      cmp("last_of_run", g.last_of_run, e.last_of_run);
    endtask
  endclass

  logic             clk, rst_n;
  logic             cfg_we;
  logic [CFGIW-1:0] cfg_index;
  logic [TW-1:0]    cfg_wdata;
  logic             in_valid, in_stall, in_last_seg;
  logic [1:0]       in_action;
  logic [TW-1:0]    in_seg_start, in_seg_end, in_query_time;
  logic [TAGW-1:0]  in_seg_tag;
  logic             out_valid, out_stall, out_hit, out_overflow, out_last_of_run;
  logic [KINDW-1:0] out_result_kind;
  logic [IDXOW-1:0] out_entry_index;
  logic [TAGW-1:0]  out_entry_tag;
  logic [TW-1:0]    out_span_start, out_span_end, out_offset_time, out_length_time;
  logic [CNTOW-1:0] out_segment_count, out_gap_count;

  index_scoreboard sb;
  int  items_sent, results_seen, idle_cycles;
  bit  quiet;

  recording_interval_index dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TW-1:0] rand_time();
    return TW'({$urandom, $urandom});
  endfunction

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [TW-1:0] v);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_window(logic [TW-1:0] ds, logic [TW-1:0] de, logic [TW-1:0] thr);
    write_reg(CFG_DAY_START, ds);
    write_reg(CFG_DAY_END, de);
    write_reg(CFG_GAP_THRESHOLD, thr);
  endtask

  task automatic send(txn_t t);
    int g;
    g = draw_gap();
    if (g > 0) begin
      @(negedge clk);
      in_valid <= 0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    in_action <= t.action; in_seg_start <= t.seg_start; in_seg_end <= t.seg_end;
    in_seg_tag <= t.seg_tag; in_last_seg <= t.last_seg; in_query_time <= t.query_time;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(t);
    items_sent++;
  endtask

  task automatic load(logic [TW-1:0] s, logic [TW-1:0] e, logic [TAGW-1:0] tag, logic last);
    txn_t t;
    t = '{action: ACT_LOAD, seg_start: s, seg_end: e, seg_tag: tag, last_seg: last,
          query_time: rand_time()};
    send(t);
  endtask

  task automatic query(action_t a, logic [TW-1:0] qt);
    txn_t t;
    t = '{action: a, seg_start: rand_time(), seg_end: rand_time(),
          seg_tag: TAGW'($urandom), last_seg: 1'($urandom), query_time: qt};
    send(t);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // time anywhere, near the window edges or near a table boundary
  function automatic logic [TW-1:0] pick_time(logic [TW-1:0] ds, logic [TW-1:0] de);
    int k;
    case ($urandom_range(0, 5))
      0: return rand_time();
      1: return ds + TW'($urandom_range(0, 200)) - TW'(100);
      2: return de + TW'($urandom_range(0, 200)) - TW'(100);
      default: begin
        if (sb.tbl_count == 0 || de <= ds) return ds + TW'($urandom_range(0, 100000));
        k = $urandom_range(0, sb.tbl_count - 1);
        case ($urandom_range(0, 3))
          0: return sb.tbl_start[k];
          1: return sb.tbl_end[k];
          2: return sb.tbl_end[k] - TW'(1);
          default: return sb.tbl_start[k] + TW'($urandom_range(0, 3000)) - TW'(1500);
        endcase
      end
    endcase
  endfunction

  task automatic random_phase();
    logic [TW-1:0] ds, de, thr, s, e;
    int nl, nq;
    case ($urandom_range(0, 5))
      0: begin ds = '0; de = TMAX; end
      1: begin ds = rand_time(); de = ds - TW'($urandom_range(0, 5)); end
      2: begin ds = rand_time() >> 1; de = ds + 63'd5000000000; end
      default: begin
        ds = TW'($urandom_range(0, 50000));
        de = ds + TW'($urandom_range(1, 200000));
      end
    endcase
    case ($urandom_range(0, 3))
      0: thr = '0;
      1: thr = TMAX;
      default: thr = TW'($urandom_range(0, 8000));
    endcase
    quiet = ($urandom_range(0, 3) == 0);
    set_window(ds, de, thr);
    nl = ($urandom_range(0, 5) == 0) ? $urandom_range(33, 36) : $urandom_range(1, 12);
    for (int i = 0; i < nl; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        s = rand_time(); e = rand_time();
      end else begin
        s = pick_time(ds, de);
        e = ($urandom_range(0, 7) == 0) ? s - TW'($urandom_range(0, 500))
                                        : s + TW'($urandom_range(1, 30000));
      end
      load(s, e, TAGW'($urandom), (i == nl - 1) && ($urandom_range(0, 9) != 0));
    end
    nq = $urandom_range(2, 10);
    for (int i = 0; i < nq; i++)
      query($urandom_range(0, 1) ? ACT_MAP : ACT_NEXT, pick_time(ds, de));
    query(ACT_EXPORT, rand_time());
    drain();
  endtask

  initial begin
    sb = new();
    items_sent = 0;
    quiet = 0;
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 0; in_action = '0; in_seg_start = '0; in_seg_end = '0;
    in_seg_tag = '0; in_last_seg = 0; in_query_time = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    set_window(63'd1000, 63'd100000, 63'd500);
    load(63'd0, 63'd5000, 16'h0000, 0);
    load(63'd500, 63'd2000, 16'h0007, 0);
    load(63'd3000, 63'd4000, 16'hFFFF, 0);
    load(63'd3000, 63'd8000, 16'h0001, 0);
    load(63'd20000, 63'd20000, 16'h0002, 0);
    load(63'd200000, 63'd300000, 16'h0003, 0);
    load(63'd50000, TMAX, 16'h0005, 1);
    query(ACT_MAP, 63'd0);
    query(ACT_MAP, 63'd1000);
    query(ACT_MAP, 63'd4999);
    query(ACT_MAP, 63'd9500);
    query(ACT_MAP, TMAX);
    query(ACT_NEXT, 63'd0);
    query(ACT_NEXT, 63'd8000);
    query(ACT_NEXT, TMAX);
    query(ACT_EXPORT, '0);
    drain();
    write_reg(CFG_DAY_END, 63'd1000);
    load(TMAX, TMAX, 16'hFFFF, 1);
    query(ACT_EXPORT, TMAX);
    drain();
    set_window(63'd10, 63'd20, TMAX);
    load(63'd30, 63'd40, 16'h1234, 1);
    query(ACT_MAP, 63'd15);
    drain();

    while (items_sent < 310) random_phase();

    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int w;
    results_seen = 0;
    out_stall = 1;
    forever begin
      w = (results_seen == 60) ? 400 : draw_gap();
      repeat (w) begin
        @(negedge clk);
        out_stall <= 1;
      end
      @(negedge clk);
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{kind: kind_t'(out_result_kind), hit: out_hit,
                        entry_index: out_entry_index, entry_tag: out_entry_tag,
                        span_start: out_span_start, span_end: out_span_end,
                        offset_time: out_offset_time, length_time: out_length_time,
                        segment_count: out_segment_count, gap_count: out_gap_count,
                        overflow: out_overflow, last_of_run: out_last_of_run});
      results_seen++;
    end
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end
endmodule
